@@ src/text_cell_buffer_engine_core_macros.svh @@
// -----------------------------------------------------------------------------
// Text cell buffer engine assertion macros
// Shared assertion forms used by the top level.
// -----------------------------------------------------------------------------
`ifndef TEXT_CELL_BUFFER_ENGINE_CORE_MACROS_SVH
`define TEXT_CELL_BUFFER_ENGINE_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define TCB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcb assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define TCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcb assertion failed");

`endif

@@ src/tcb_pkg.sv @@
// -----------------------------------------------------------------------------
// Text cell buffer package
// Command codes, payload types and controller interface structs.
// -----------------------------------------------------------------------------
`default_nettype none
package tcb_pkg;

    localparam logic [3:0] CMD_WRITE   = 4'd0;
    localparam logic [3:0] CMD_CLRAREA = 4'd1;
    localparam logic [3:0] CMD_CLRSCR  = 4'd2;
    localparam logic [3:0] CMD_ATTR    = 4'd3;
    localparam logic [3:0] CMD_FG      = 4'd4;
    localparam logic [3:0] CMD_COLOURS = 4'd5;
    localparam logic [3:0] CMD_CURSOR  = 4'd6;
    localparam logic [3:0] CMD_SYNC    = 4'd7;
    localparam logic [3:0] CMD_READ    = 4'd8;

    localparam logic [20:0] BLANK_GLYPH = 21'h20;
    localparam logic [15:0] PEN_FORE_RST = 16'd2;

    typedef struct packed {
        logic [3:0]        command;
        logic signed [7:0] col;
        logic signed [7:0] row;
        logic signed [7:0] col_end;
        logic signed [7:0] row_end;
        logic [20:0]       glyph;
        logic [15:0]       keep_mask;
        logic [15:0]       set_mask;
        logic [15:0]       fore_colour;
        logic [15:0]       back_colour;
        logic              show_cursor;
    } t_req;

    typedef struct packed {
        logic [20:0]       cell_glyph;
        logic [15:0]       cell_fore;
        logic [15:0]       cell_back;
        logic [15:0]       cell_attr;
        logic              cell_valid;
        logic [31:0]       frames;
        logic signed [7:0] cursor_x;
        logic signed [7:0] cursor_y;
        logic              cursor_on;
    } t_rsp;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture request, set up walk bounds
        logic reg_op;    // apply pen/cursor update
        logic paint;     // write back cell at walk or request position
        logic copy_rd;   // read back cell at walk position
        logic copy_wr;   // write front cell from read data
        logic step;      // advance walk position
        logic init;      // reset clearing pass write
        logic rd_front;  // read front cell at request position
        logic frame_inc; // count a frame
        logic rsp_load;  // latch the result
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic walk_last; // walk position is the final cell
        logic walk_empty;// clipped area holds no cell
        logic on_screen; // request cell is on screen
    } t_sts;

endpackage
`default_nettype wire

@@ src/tcb_stream_if.sv @@
// -----------------------------------------------------------------------------
// Text cell buffer stream interface
// Valid/ready channel carrying one payload.
// -----------------------------------------------------------------------------
`default_nettype none
interface tcb_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/tcb_ctrl.sv @@
// -----------------------------------------------------------------------------
// Text cell buffer controller
// Sequences reset clearing, command walks, copies, reads and result hand-off.
// -----------------------------------------------------------------------------
`default_nettype none
module tcb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [3:0]    i_command,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output tcb_pkg::t_cmd      o_cmd,
    input  wire tcb_pkg::t_sts i_sts
);
    typedef enum logic [7:0] {
        ST_INIT  = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_EXEC  = 8'b0000_0100,
        ST_PAINT = 8'b0000_1000,
        ST_CPRD  = 8'b0001_0000,
        ST_CPWR  = 8'b0010_0000,
        ST_READ  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic [3:0] r_cmd, n_cmd;
    logic   w_rsp_free;

    assign w_rsp_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.init = 1'b1;
                o_cmd.step = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cmd      = i_command;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (r_cmd)
                    tcb_pkg::CMD_WRITE: begin
                        o_cmd.paint = i_sts.on_screen;
                        n_state     = ST_DONE;
                    end
                    tcb_pkg::CMD_CLRAREA, tcb_pkg::CMD_CLRSCR: begin
                        n_state = i_sts.walk_empty ? ST_DONE : ST_PAINT;
                    end
                    tcb_pkg::CMD_SYNC: begin
                        n_state = ST_CPRD;
                    end
                    tcb_pkg::CMD_READ: begin
                        o_cmd.rd_front = 1'b1;
                        n_state        = ST_READ;
                    end
                    default: begin
                        o_cmd.reg_op = 1'b1;
                        n_state      = ST_DONE;
                    end
                endcase
            end
            ST_PAINT: begin
                o_cmd.paint = 1'b1;
                o_cmd.step  = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_CPRD: begin
                o_cmd.copy_rd = 1'b1;
                n_state       = ST_CPWR;
            end
            ST_CPWR: begin
                o_cmd.copy_wr = 1'b1;
                o_cmd.step    = 1'b1;
                if (i_sts.walk_last) begin
                    o_cmd.frame_inc = 1'b1;
                    n_state         = ST_DONE;
                end else begin
                    n_state = ST_CPRD;
                end
            end
            ST_READ: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_rsp_free) begin
                    o_cmd.rsp_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
            r_cmd       <= tcb_pkg::CMD_WRITE;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cmd       <= n_cmd;
        end
    end
endmodule
`default_nettype wire

@@ src/tcb_datapath.sv @@
// -----------------------------------------------------------------------------
// Text cell buffer datapath
// Back and front cell memories, pen and cursor registers, walk counters.
// -----------------------------------------------------------------------------
`default_nettype none
module tcb_datapath #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tcb_pkg::t_req i_req,
    input  wire tcb_pkg::t_cmd i_cmd,
    output tcb_pkg::t_sts      o_sts,
    output tcb_pkg::t_rsp      o_rsp
);
    localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(SCREEN_COLS + 1);
    localparam int YW    = $clog2(SCREEN_ROWS + 1);
    localparam int CW    = 21 + 32 + 16;
    localparam logic signed [8:0] COL_MAX = 9'(SCREEN_COLS - 1);
    localparam logic signed [8:0] ROW_MAX = 9'(SCREEN_ROWS - 1);

    logic [CW-1:0] r_back  [CELLS];
    logic [CW-1:0] r_front [CELLS];
    logic [CW-1:0] r_bdat;
    logic [CW-1:0] r_fdat;

    tcb_pkg::t_req r_req;
    logic [15:0] r_pen_fore, r_pen_back, r_pen_attr;
    logic [31:0] r_frames;
    logic signed [7:0] r_cur_x, r_cur_y;
    logic r_cur_on;
    logic [XW-1:0] r_x, r_x0, r_x1;
    logic [YW-1:0] r_y, r_y1;
    logic [AW-1:0] r_addr, r_row_base;
    logic r_empty;
    logic r_rd_valid;
    tcb_pkg::t_rsp r_rsp;

    logic signed [8:0] w_x0, w_y0, w_x1, w_y1;
    logic w_on;
    logic [AW-1:0] w_req_addr;
    logic [CW-1:0] w_pen_cell;

    always_comb begin
        w_x0 = (i_req.command == tcb_pkg::CMD_CLRAREA && i_req.col >= 0)
               ? 9'(i_req.col) : 9'sd0;
        w_y0 = (i_req.command == tcb_pkg::CMD_CLRAREA && i_req.row >= 0)
               ? 9'(i_req.row) : 9'sd0;
        w_x1 = COL_MAX;
        w_y1 = ROW_MAX;
        if (i_req.command == tcb_pkg::CMD_CLRAREA) begin
            if (9'(i_req.col_end) < COL_MAX) w_x1 = 9'(i_req.col_end);
            if (9'(i_req.row_end) < ROW_MAX) w_y1 = 9'(i_req.row_end);
        end
    end

    assign w_on = (r_req.col >= 0) && (r_req.row >= 0)
                  && (9'(r_req.col) <= COL_MAX) && (9'(r_req.row) <= ROW_MAX);
    assign w_req_addr = AW'(AW'(r_req.row[6:0]) * AW'(SCREEN_COLS)) + AW'(r_req.col[6:0]);
    assign w_pen_cell = {((r_req.command == tcb_pkg::CMD_WRITE) ? r_req.glyph
                          : tcb_pkg::BLANK_GLYPH), r_pen_back, r_pen_fore, r_pen_attr};

    assign o_sts.walk_last  = (r_x == r_x1) && (r_y == r_y1);
    assign o_sts.walk_empty = r_empty;
    assign o_sts.on_screen  = w_on;
    assign o_rsp = r_rsp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_back[r_addr]  <= {tcb_pkg::BLANK_GLYPH, 32'd0, 16'd0};
            r_front[r_addr] <= {tcb_pkg::BLANK_GLYPH, 32'd0, 16'd0};
        end else if (i_cmd.paint) begin
            r_back[(r_req.command == tcb_pkg::CMD_WRITE) ? w_req_addr : r_addr]
                <= w_pen_cell;
        end else if (i_cmd.copy_wr) begin
            r_front[r_addr] <= r_bdat;
        end
        if (i_cmd.copy_rd) begin
            r_bdat <= r_back[r_addr];
        end
        if (i_cmd.rd_front) begin
            r_fdat <= r_front[w_req_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.rsp_load) begin
            r_rsp.cell_glyph <= r_rd_valid ? r_fdat[CW-1 -: 21] : 21'd0;
            r_rsp.cell_back  <= r_rd_valid ? r_fdat[47:32] : 16'd0;
            r_rsp.cell_fore  <= r_rd_valid ? r_fdat[31:16] : 16'd0;
            r_rsp.cell_attr  <= r_rd_valid ? r_fdat[15:0] : 16'd0;
            r_rsp.cell_valid <= r_rd_valid;
            r_rsp.frames     <= r_frames;
            r_rsp.cursor_x   <= r_cur_x;
            r_rsp.cursor_y   <= r_cur_y;
            r_rsp.cursor_on  <= r_cur_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_fore <= tcb_pkg::PEN_FORE_RST;
            r_pen_back <= '0;
            r_pen_attr <= '0;
            r_frames   <= '0;
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_cur_on   <= 1'b1;
            r_x  <= '0; r_x0 <= '0; r_x1 <= XW'(SCREEN_COLS - 1);
            r_y  <= '0; r_y1 <= YW'(SCREEN_ROWS - 1);
            r_addr <= '0; r_row_base <= '0;
            r_empty <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_empty <= (w_x0 > w_x1) || (w_y0 > w_y1);
                r_x  <= XW'(w_x0); r_x0 <= XW'(w_x0); r_x1 <= XW'(w_x1);
                r_y  <= YW'(w_y0); r_y1 <= YW'(w_y1);
                r_row_base <= AW'(AW'(w_y0[6:0]) * AW'(SCREEN_COLS));
                r_addr <= AW'(AW'(w_y0[6:0]) * AW'(SCREEN_COLS)) + AW'(w_x0[6:0]);
                r_rd_valid <= 1'b0;
            end else if (i_cmd.step) begin
                if (r_x == r_x1) begin
                    r_x        <= r_x0;
                    r_y        <= r_y + 1'b1;
                    r_row_base <= r_row_base + AW'(SCREEN_COLS);
                    r_addr     <= r_row_base + AW'(SCREEN_COLS) + AW'(r_x0);
                end else begin
                    r_x    <= r_x + 1'b1;
                    r_addr <= r_addr + 1'b1;
                end
            end
            if (i_cmd.rd_front) begin
                r_rd_valid <= w_on;
            end
            if (i_cmd.frame_inc) begin
                r_frames <= r_frames + 32'd1;
            end
            if (i_cmd.reg_op) begin
                unique case (r_req.command)
                    tcb_pkg::CMD_ATTR:
                        r_pen_attr <= (r_pen_attr & r_req.keep_mask) | r_req.set_mask;
                    tcb_pkg::CMD_FG:
                        r_pen_fore <= r_req.fore_colour;
                    tcb_pkg::CMD_COLOURS: begin
                        r_pen_fore <= r_req.fore_colour;
                        r_pen_back <= r_req.back_colour;
                    end
                    tcb_pkg::CMD_CURSOR: begin
                        r_cur_x  <= r_req.col;
                        r_cur_y  <= r_req.row;
                        r_cur_on <= r_req.show_cursor;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end
endmodule
`default_nettype wire

@@ src/text_cell_buffer_engine_core.sv @@
// Clear area and clear screen paint each clipped cell in turn; sync reads each
// back cell and writes it to the front buffer, then counts a frame.
// One command is in flight at a time; the result register frees the next input.
// After reset a clearing pass over all SCREEN_COLS*SCREEN_ROWS cells (1920)
// fills both buffers before the first request is accepted.
`default_nettype none
`include "text_cell_buffer_engine_core_macros.svh"
// -----------------------------------------------------------------------------
// Text cell buffer engine top level
// Double-buffered character-cell store with one result per request.
// -----------------------------------------------------------------------------
module text_cell_buffer_engine_core #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcb_stream_if.sink   i_req,
    tcb_stream_if.source o_rsp
);
    tcb_pkg::t_cmd w_cmd;
    tcb_pkg::t_sts w_sts;
    tcb_pkg::t_rsp w_rsp;

    tcb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_command   (i_req.data.command),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    tcb_datapath #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req.data),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_rsp   (w_rsp)
    );

    assign o_rsp.data = w_rsp;

    `TCB_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, w_cmd.load, i_req.ready)
    `TCB_ASSERT_NEXT(a_rsp_after_load, i_clk, i_rst_n, w_cmd.rsp_load, o_rsp.valid)
    `TCB_ASSERT_IMP(a_one_mem_op, i_clk, i_rst_n, w_cmd.paint,
        !w_cmd.copy_wr && !w_cmd.init)
endmodule
`default_nettype wire

@@ dv/tb_text_cell_buffer_engine_core.sv @@
// -----------------------------------------------------------------------------
// Text cell buffer engine testbench
// Drives command requests through the stream interfaces and compares every
// response with a behavioral model of the back and front cell buffers.
// -----------------------------------------------------------------------------
`default_nettype none
module tb_text_cell_buffer_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS = 80;
    localparam int ROWS = 24;
    localparam int CELLS = COLS * ROWS;

    class cell_scoreboard;
        logic [20:0] back_glyph [CELLS];
        logic [31:0] back_pair  [CELLS];
        logic [15:0] back_attr  [CELLS];
        logic [20:0] front_glyph[CELLS];
        logic [31:0] front_pair [CELLS];
        logic [15:0] front_attr [CELLS];
        logic [15:0] pen_fore, pen_back, pen_attr;
        logic [31:0] frame_count;
        logic signed [7:0] cur_x, cur_y;
        logic cur_on;
        tcb_pkg::t_rsp pending[$];
        int errors;

        function new();
            for (int i = 0; i < CELLS; i++) begin
                back_glyph[i] = tcb_pkg::BLANK_GLYPH;
                front_glyph[i] = tcb_pkg::BLANK_GLYPH;
                back_pair[i] = '0;
                front_pair[i] = '0;
                back_attr[i] = '0;
                front_attr[i] = '0;
            end
            pen_fore = tcb_pkg::PEN_FORE_RST;
            pen_back = '0;
            pen_attr = '0;
            frame_count = '0;
            cur_x = '0;
            cur_y = '0;
            cur_on = 1'b1;
            errors = 0;
        endfunction

        function void paint(int idx, logic [20:0] g);
            back_glyph[idx] = g;
            back_pair[idx] = {pen_back, pen_fore};
            back_attr[idx] = pen_attr;
        endfunction

        function bit visible(int x, int y);
            return x >= 0 && y >= 0 && x < COLS && y < ROWS;
        endfunction

        function void note_request(tcb_pkg::t_req r);
            tcb_pkg::t_rsp e;
            int x0, y0, x1, y1, idx;
            e = '0;
            x0 = r.col;
            y0 = r.row;
            x1 = r.col_end;
            y1 = r.row_end;
            case (r.command)
                tcb_pkg::CMD_WRITE: if (visible(x0, y0)) paint(y0 * COLS + x0, r.glyph);
                tcb_pkg::CMD_CLRAREA: begin
                    if (x0 < 0) x0 = 0;
                    if (y0 < 0) y0 = 0;
                    if (x1 >= COLS) x1 = COLS - 1;
                    if (y1 >= ROWS) y1 = ROWS - 1;
                    for (int cy = y0; cy <= y1; cy++)
                        for (int cx = x0; cx <= x1; cx++)
                            paint(cy * COLS + cx, tcb_pkg::BLANK_GLYPH);
                end
                tcb_pkg::CMD_CLRSCR:
                    for (int i = 0; i < CELLS; i++) paint(i, tcb_pkg::BLANK_GLYPH);
                tcb_pkg::CMD_ATTR: pen_attr = (pen_attr & r.keep_mask) | r.set_mask;
                tcb_pkg::CMD_FG: pen_fore = r.fore_colour;
                tcb_pkg::CMD_COLOURS: begin
                    pen_fore = r.fore_colour;
                    pen_back = r.back_colour;
                end
                tcb_pkg::CMD_CURSOR: begin
                    cur_x = r.col;
                    cur_y = r.row;
                    cur_on = r.show_cursor;
                end
                tcb_pkg::CMD_SYNC: begin
                    front_glyph = back_glyph;
                    front_pair = back_pair;
                    front_attr = back_attr;
                    frame_count++;
                end
                tcb_pkg::CMD_READ: if (visible(x0, y0)) begin
                    idx = y0 * COLS + x0;
                    e.cell_glyph = front_glyph[idx];
                    e.cell_fore = front_pair[idx][15:0];
                    e.cell_back = front_pair[idx][31:16];
                    e.cell_attr = front_attr[idx];
                    e.cell_valid = 1'b1;
                end
                default: ;
            endcase
            e.frames = frame_count;
            e.cursor_x = cur_x;
            e.cursor_y = cur_y;
            e.cursor_on = cur_on;
            pending.push_back(e);
        endfunction

        function void check_response(tcb_pkg::t_rsp a);
            tcb_pkg::t_rsp e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected response %h", a);
                return;
            end
            e = pending.pop_front();
            if (a !== e) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %h actual %h", e, a);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    cell_scoreboard sb;

    tcb_stream_if #(.T(tcb_pkg::t_req)) req_if ();
    tcb_stream_if #(.T(tcb_pkg::t_rsp)) rsp_if ();

    text_cell_buffer_engine_core #(.SCREEN_COLS(COLS), .SCREEN_ROWS(ROWS)) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
    end

    // Response side: random stalls, check at every accepted response.
    initial begin
        int gap;
        sb = new();
        @(posedge clk iff rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (gap != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk iff rsp_if.valid);
            sb.check_response(rsp_if.data);
        end
    end

    function automatic tcb_pkg::t_req random_request();
        tcb_pkg::t_req r;
        int pick;
        r.command = 4'($urandom_range(0, 8));
        pick = $urandom_range(0, 9);
        if (pick == 0) r.command = 4'($urandom_range(9, 15));
        if (pick <= 2) begin
            r.col = 8'($urandom);
            r.row = 8'($urandom);
        end else begin
            r.col = 8'($urandom_range(0, COLS - 1));
            r.row = 8'($urandom_range(0, ROWS - 1));
        end
        r.col_end = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                : 8'(r.col + $urandom_range(0, 6));
        r.row_end = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                : 8'(r.row + $urandom_range(0, 3));
        r.glyph = 21'($urandom);
        r.keep_mask = 16'($urandom);
        r.set_mask = 16'($urandom);
        r.fore_colour = 16'($urandom);
        r.back_colour = 16'($urandom);
        r.show_cursor = 1'($urandom);
        if (r.command == tcb_pkg::CMD_CLRSCR && $urandom_range(0, 3) != 0)
            r.command = tcb_pkg::CMD_WRITE;
        if (r.command == tcb_pkg::CMD_SYNC && $urandom_range(0, 2) != 0)
            r.command = tcb_pkg::CMD_READ;
        return r;
    endfunction

    task automatic send_request(tcb_pkg::t_req r);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= r;
        @(posedge clk iff req_if.ready);
        sb.note_request(r);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    function automatic tcb_pkg::t_req make_request(logic [3:0] c, int x, int y, int xe,
                                                   int ye, logic [20:0] g);
        tcb_pkg::t_req r;
        r = '0;
        r.command = c;
        r.col = 8'(x);
        r.row = 8'(y);
        r.col_end = 8'(xe);
        r.row_end = 8'(ye);
        r.glyph = g;
        r.keep_mask = 16'h00ff;
        r.set_mask = 16'hff00;
        r.fore_colour = 16'hffff;
        r.back_colour = 16'h8001;
        r.show_cursor = 1'b0;
        return r;
    endfunction

    initial begin
        tcb_pkg::t_req d[$];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        d.push_back(make_request(tcb_pkg::CMD_READ, 0, 0, 0, 0, 0));
        d.push_back(make_request(tcb_pkg::CMD_COLOURS, 0, 0, 0, 0, 0));
        d.push_back(make_request(tcb_pkg::CMD_ATTR, 0, 0, 0, 0, 0));
        d.push_back(make_request(tcb_pkg::CMD_WRITE, 0, 0, 0, 0, 21'h1fffff));
        d.push_back(make_request(tcb_pkg::CMD_WRITE, COLS - 1, ROWS - 1, 0, 0, 21'h10ffff));
        d.push_back(make_request(tcb_pkg::CMD_WRITE, -1, 5, 0, 0, 21'h41));
        d.push_back(make_request(tcb_pkg::CMD_WRITE, 5, ROWS, 0, 0, 21'h42));
        d.push_back(make_request(tcb_pkg::CMD_FG, 0, 0, 0, 0, 0));
        d.push_back(make_request(tcb_pkg::CMD_CLRAREA, -128, -128, 2, 1, 0));
        d.push_back(make_request(tcb_pkg::CMD_CLRAREA, 70, 20, 127, 127, 0));
        d.push_back(make_request(tcb_pkg::CMD_CLRAREA, 10, 10, 5, 5, 0));
        d.push_back(make_request(tcb_pkg::CMD_SYNC, 0, 0, 0, 0, 0));
        d.push_back(make_request(tcb_pkg::CMD_READ, 0, 0, 0, 0, 0));
        d.push_back(make_request(tcb_pkg::CMD_READ, COLS - 1, ROWS - 1, 0, 0, 0));
        d.push_back(make_request(tcb_pkg::CMD_READ, 127, -128, 0, 0, 0));
        d.push_back(make_request(tcb_pkg::CMD_READ, COLS, 0, 0, 0, 0));
        d.push_back(make_request(tcb_pkg::CMD_CURSOR, -128, 127, 0, 0, 0));
        d.push_back(make_request(4'd15, 0, 0, 0, 0, 0));
        d.push_back(make_request(tcb_pkg::CMD_CLRSCR, 0, 0, 0, 0, 0));
        d.push_back(make_request(tcb_pkg::CMD_SYNC, 0, 0, 0, 0, 0));
        d.push_back(make_request(tcb_pkg::CMD_READ, 3, 3, 0, 0, 0));
        d.push_back(make_request(tcb_pkg::CMD_CURSOR, 127, -1, 0, 0, 0));
        foreach (d[i]) send_request(d[i]);
        req_if.valid <= 1'b0;
        wait_drained();
        for (int n = 0; n < 800; n++) send_request(random_request());
        req_if.valid <= 1'b0;
        wait_drained();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
